// ===== design/ear_clipping_triangulator_defines.svh =====
// Assertion macros for the ear clipping triangulator.
// Needs clk and rst in scope at the point of use.
`ifndef EAR_CLIPPING_TRIANGULATOR_DEFINES_SVH
`define EAR_CLIPPING_TRIANGULATOR_DEFINES_SVH

// Property that must hold in every cycle outside reset.
`define ECT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Trigger in one cycle implies a condition in the next.
`define ECT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) else $error(msg);

`endif

// ===== design/ect_pkg.sv =====
// Shared types, constants and geometry functions for the ear clipping triangulator.
// No dependencies.
package ect_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int COORD_BITS   = 16;
  localparam int IDX_W        = $clog2(MAX_VERTICES);
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
  localparam int AREA_W       = 40;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
  } pt_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_TOO_FEW = 2'd1,
    ST_NO_EAR  = 2'd2,
    ST_OVF     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_MOVE,
    CELL_DROP
  } cell_op_t;

  // Broadcast to every cell of the ring.
  typedef struct packed {
    cell_op_t         op;
    logic [IDX_W-1:0] m;
    pt_t              data;
  } cell_ctl_t;

  typedef enum logic [3:0] {
    S_LOAD,
    S_CLOSE,
    S_ORIENT,
    S_REV,
    S_ROT,
    S_CHECKN,
    S_CAND,
    S_CONVEX,
    S_SCAN,
    S_NEXT,
    S_OUT,
    S_DROP
  } state_t;

  // Sign of det(p - o, q - o): bit 1 = positive, bit 0 = negative.
  function automatic logic [1:0] orient(pt_t o, pt_t p, pt_t q);
    logic signed [COORD_BITS:0]     a, b, c, d;
    logic signed [2*COORD_BITS+1:0] pr, qr;
    a  = (COORD_BITS+1)'(p.x) - (COORD_BITS+1)'(o.x);
    b  = (COORD_BITS+1)'(p.y) - (COORD_BITS+1)'(o.y);
    c  = (COORD_BITS+1)'(q.x) - (COORD_BITS+1)'(o.x);
    d  = (COORD_BITS+1)'(q.y) - (COORD_BITS+1)'(o.y);
    pr = (2*COORD_BITS+2)'(a) * (2*COORD_BITS+2)'(d);
    qr = (2*COORD_BITS+2)'(b) * (2*COORD_BITS+2)'(c);
    return {pr > qr, pr < qr};
  endfunction

  // One shoelace term a.x*b.y - b.x*a.y, sign-extended to the accumulator width.
  function automatic logic [AREA_W-1:0] shoelace(pt_t a, pt_t b);
    logic signed [2*COORD_BITS-1:0] p1, p2;
    logic signed [2*COORD_BITS:0]   dif;
    p1  = (2*COORD_BITS)'(a.x) * (2*COORD_BITS)'(b.y);
    p2  = (2*COORD_BITS)'(b.x) * (2*COORD_BITS)'(a.y);
    dif = (2*COORD_BITS+1)'(p1) - (2*COORD_BITS+1)'(p2);
    return AREA_W'(dif);
  endfunction

endpackage

// ===== design/ect_ifs.sv =====
// Valid/ready channel interfaces for vertices in and triangles out.
// Depends on ect_pkg.
interface ect_in_if import ect_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] vert_x;
  logic signed [COORD_BITS-1:0] vert_y;
  logic                         last_vertex;

  modport source (output valid, vert_x, vert_y, last_vertex, input ready);
  modport sink (input valid, vert_x, vert_y, last_vertex, output ready);
endinterface

interface ect_out_if import ect_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] ax;
  logic signed [COORD_BITS-1:0] ay;
  logic signed [COORD_BITS-1:0] bx;
  logic signed [COORD_BITS-1:0] by;
  logic signed [COORD_BITS-1:0] cx;
  logic signed [COORD_BITS-1:0] cy;
  logic                         tri_valid;
  logic                         last_result;
  logic [1:0]                   status;

  modport source (output valid, ax, ay, bx, by, cx, cy, tri_valid, last_result, status,
                  input ready);
  modport sink (input valid, ax, ay, bx, by, cx, cy, tri_valid, last_result, status,
                output ready);
endinterface

// ===== design/ect_cell.sv =====
// One vertex cell of the ring: load, move-head-to-slot and drop operations.
// Depends on ect_pkg.
module ect_cell import ect_pkg::*; (
  input  logic             clk,
  input  cell_ctl_t        ctl,
  input  logic [IDX_W-1:0] idx,
  input  pt_t              nxt,
  input  pt_t              head,
  output pt_t              q
);

  always_ff @(posedge clk) begin
    case (ctl.op)
      CELL_LOAD: if (idx == ctl.m) q <= ctl.data;
      CELL_MOVE: begin
        // slots below m shift toward the head, slot m takes the old head
        if (idx < ctl.m) q <= nxt;
        else if (idx == ctl.m) q <= head;
      end
      CELL_DROP: if (idx != '0) q <= nxt;
      default: ;
    endcase
  end

endmodule

// ===== design/ect_tri_test.sv =====
// Convexity and point-in-triangle test against the ring head.
// Depends on ect_pkg.
module ect_tri_test import ect_pkg::*; (
  input  pt_t  r,
  input  pt_t  l,
  input  pt_t  v,
  input  pt_t  p,
  output logic convex,
  output logic contains
);

  logic [1:0] d1, d2, d3, dc;

  always_comb begin
    d1 = orient(r, l, p);
    d2 = orient(l, v, p);
    d3 = orient(v, r, p);
    dc = orient(v, l, r);
    // edges and corners count as inside
    contains = !((d1[0] | d2[0] | d3[0]) && (d1[1] | d2[1] | d3[1]));
    convex   = !dc[0];
  end

endmodule

// ===== design/ear_clipping_triangulator.sv =====
// Ear clipping triangulator. Vertices enter one per cycle into a
// ring of 64 cells; the vertex marked last closes the polygon and the block
// stops taking vertices until its final result has been transferred. After
// the close it adds the closing edge to the area, decides the orientation,
// reverses a counterclockwise list and aligns the ring. Each candidate
// vertex is then tested for convexity and, when convex, a pass rotates
// the whole ring past the containment tester; clipping an ear waits for the
// result transfer, then drops the vertex, realigns and restarts the scan.
// The ring makes at most a single rotation step per cycle. A polygon
// with too few vertices, an overfilled store or no ear ends in one
// status-only result.
// Depends on ect_pkg, ect_ifs, ect_cell, ect_tri_test and the defines header.
`include "ear_clipping_triangulator_defines.svh"

module ear_clipping_triangulator import ect_pkg::*; (
  input logic       clk,
  input logic       rst,
  ect_in_if.sink    vertices,
  ect_out_if.source triangles
);

  state_t            state, state_next;
  logic [CNT_W-1:0]  n, n_next;           // vertices in the ring
  logic [IDX_W-1:0]  i, i_next;           // candidate index
  logic [IDX_W-1:0]  t, t_next;           // step within a pass
  logic [IDX_W-1:0]  cnt, cnt_next;       // rotations still to do
  logic              blocked, blocked_next;
  logic [AREA_W-1:0] area, area_next;
  logic              ovf, ovf_next;
  pt_t               lastv, lastv_next;   // most recently stored vertex
  pt_t               tl, tl_next, tv, tv_next, tr, tr_next;
  pt_t               oa, oa_next, ob, ob_next, oc, oc_next;
  logic              ovalid, ovalid_next;
  logic              otri, otri_next;
  logic              olast, olast_next;
  status_t           ostat, ostat_next;

  cell_ctl_t         ctl;
  pt_t               ring [MAX_VERTICES];
  pt_t               pin;
  logic              convex, contains;
  logic              in_xfer, out_xfer, hit;
  logic [IDX_W-1:0]  ring_last;

  // Ring of cells. Slot 0 is the head; a move rotates within the first n slots.
  for (genvar k = 0; k < MAX_VERTICES; k++) begin : g_cell
    ect_cell u_cell (
      .clk  (clk),
      .ctl  (ctl),
      .idx  (IDX_W'(k)),
      .nxt  (ring[(k < MAX_VERTICES - 1) ? k + 1 : k]),
      .head (ring[0]),
      .q    (ring[k])
    );
  end

  // Triangle (right, left, clipped) held in tr/tl/tv; the head is the probe.
  ect_tri_test u_test (
    .r        (tr),
    .l        (tl),
    .v        (tv),
    .p        (ring[0]),
    .convex   (convex),
    .contains (contains)
  );

  assign pin       = '{x: vertices.vert_x, y: vertices.vert_y};
  assign in_xfer   = vertices.valid && vertices.ready;
  assign out_xfer  = triangles.valid && triangles.ready;
  assign ring_last = IDX_W'(n - CNT_W'(1));
  // steps 0..2 of a pass put the left, clipped and right corners at the head
  assign hit       = (t >= IDX_W'(3)) && contains;

  assign vertices.ready        = (state == S_LOAD);
  assign triangles.valid       = ovalid;
  assign triangles.ax          = oa.x;
  assign triangles.ay          = oa.y;
  assign triangles.bx          = ob.x;
  assign triangles.by          = ob.y;
  assign triangles.cx          = oc.x;
  assign triangles.cy          = oc.y;
  assign triangles.tri_valid   = otri;
  assign triangles.last_result = olast;
  assign triangles.status      = ostat;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_LOAD;
      n      <= '0;
      area   <= '0;
      ovf    <= 1'b0;
      ovalid <= 1'b0;
    end else begin
      state  <= state_next;
      n      <= n_next;
      area   <= area_next;
      ovf    <= ovf_next;
      ovalid <= ovalid_next;
    end
    i       <= i_next;
    t       <= t_next;
    cnt     <= cnt_next;
    blocked <= blocked_next;
    lastv   <= lastv_next;
    tl      <= tl_next;
    tv      <= tv_next;
    tr      <= tr_next;
    oa      <= oa_next;
    ob      <= ob_next;
    oc      <= oc_next;
    otri    <= otri_next;
    olast   <= olast_next;
    ostat   <= ostat_next;
  end

  always_comb begin
    state_next   = state;
    n_next       = n;
    i_next       = i;
    t_next       = t;
    cnt_next     = cnt;
    blocked_next = blocked;
    area_next    = area;
    ovf_next     = ovf;
    lastv_next   = lastv;
    tl_next      = tl;
    tv_next      = tv;
    tr_next      = tr;
    oa_next      = oa;
    ob_next      = ob;
    oc_next      = oc;
    ovalid_next  = ovalid;
    otri_next    = otri;
    olast_next   = olast;
    ostat_next   = ostat;
    ctl.op       = CELL_HOLD;
    ctl.m        = '0;
    ctl.data     = pin;

    unique case (state)
      S_LOAD: begin
        if (in_xfer) begin
          if (n < CNT_W'(MAX_VERTICES)) begin
            ctl.op     = CELL_LOAD;
            ctl.m      = IDX_W'(n);
            lastv_next = pin;
            n_next     = n + CNT_W'(1);
            if (n != '0) area_next = area + shoelace(lastv, pin);
          end else begin
            ovf_next = 1'b1;
          end
          if (vertices.last_vertex) state_next = S_CLOSE;
        end
      end
      S_CLOSE: begin
        if (ovf || n < CNT_W'(3)) begin
          oa_next     = '0;
          ob_next     = '0;
          oc_next     = '0;
          ovalid_next = 1'b1;
          otri_next   = 1'b0;
          olast_next  = 1'b1;
          ostat_next  = ovf ? ST_OVF : ST_TOO_FEW;
          state_next  = S_OUT;
        end else begin
          // closing edge from the last vertex back to the first
          area_next  = area + shoelace(lastv, ring[0]);
          state_next = S_ORIENT;
        end
      end
      S_ORIENT: begin
        if (!area[AREA_W-1]) begin
          t_next     = '0;
          state_next = S_REV;
        end else begin
          cnt_next   = ring_last;
          state_next = S_ROT;
        end
      end
      S_REV: begin
        // move the head to slot n-1-t; after n-1 moves the list is reversed
        ctl.op = CELL_MOVE;
        ctl.m  = ring_last - t;
        if (t == ring_last - IDX_W'(1)) begin
          cnt_next   = ring_last;
          state_next = S_ROT;
        end else begin
          t_next = t + IDX_W'(1);
        end
      end
      S_ROT: begin
        // realign so the head holds the last vertex, slot 1 the first
        if (cnt == '0) begin
          state_next = S_CHECKN;
        end else begin
          ctl.op   = CELL_MOVE;
          ctl.m    = ring_last;
          cnt_next = cnt - IDX_W'(1);
        end
      end
      S_CHECKN: begin
        if (n == CNT_W'(3)) begin
          oa_next     = ring[1];
          ob_next     = ring[2];
          oc_next     = ring[0];
          ovalid_next = 1'b1;
          otri_next   = 1'b1;
          olast_next  = 1'b1;
          ostat_next  = ST_OK;
          state_next  = S_OUT;
        end else begin
          i_next     = '0;
          state_next = S_CAND;
        end
      end
      S_CAND: begin
        tl_next    = ring[0];
        tv_next    = ring[1];
        tr_next    = ring[2];
        state_next = S_CONVEX;
      end
      S_CONVEX: begin
        if (convex) begin
          t_next       = '0;
          blocked_next = 1'b0;
          state_next   = S_SCAN;
        end else begin
          state_next = S_NEXT;
        end
      end
      S_SCAN: begin
        // a full turn brings every vertex past the head and restores the ring
        ctl.op = CELL_MOVE;
        ctl.m  = ring_last;
        if (hit) blocked_next = 1'b1;
        if (t == ring_last) begin
          if (blocked || hit) begin
            state_next = S_NEXT;
          end else begin
            oa_next     = tr;
            ob_next     = tl;
            oc_next     = tv;
            ovalid_next = 1'b1;
            otri_next   = 1'b1;
            olast_next  = 1'b0;
            ostat_next  = ST_OK;
            state_next  = S_OUT;
          end
        end else begin
          t_next = t + IDX_W'(1);
        end
      end
      S_NEXT: begin
        if (i == ring_last) begin
          oa_next     = '0;
          ob_next     = '0;
          oc_next     = '0;
          ovalid_next = 1'b1;
          otri_next   = 1'b0;
          olast_next  = 1'b1;
          ostat_next  = ST_NO_EAR;
          state_next  = S_OUT;
        end else begin
          ctl.op     = CELL_MOVE;
          ctl.m      = ring_last;
          i_next     = i + IDX_W'(1);
          state_next = S_CAND;
        end
      end
      S_OUT: begin
        if (out_xfer) begin
          ovalid_next = 1'b0;
          if (olast) begin
            n_next     = '0;
            area_next  = '0;
            ovf_next   = 1'b0;
            state_next = S_LOAD;
          end else begin
            state_next = S_DROP;
          end
        end
      end
      S_DROP: begin
        // remove the clipped vertex in slot 1, then rotate back to alignment
        ctl.op     = CELL_DROP;
        n_next     = n - CNT_W'(1);
        cnt_next   = ring_last - i;
        state_next = S_ROT;
      end
      default: state_next = S_LOAD;
    endcase
  end

  `ECT_ALWAYS(a_no_overlap, !(vertices.ready && ovalid), "input open while result pending")
  `ECT_ALWAYS(a_count_range, n <= CNT_W'(MAX_VERTICES), "vertex count beyond store")
  `ECT_NEXT(a_last_clears, out_xfer && olast, n == '0 && state == S_LOAD && !ovf, "no clear after last")
  `ECT_NEXT(a_drop_shrinks, state == S_DROP, n == $past(n) - CNT_W'(1), "drop did not shrink ring")

endmodule
